// ===== rtl/core/sle_pkg.sv =====
// Shared definitions for the serial line editor with echo.
// Holds default sizes, character codes, field codes, state and control/status types.
// No dependencies; the other files in rtl/core, apart from sle_ram, refer to it by scoped names.
package sle_pkg;

    // Default sizes of the two byte stores.
    localparam int LINE_DEPTH_DEF = 32;
    localparam int TX_DEPTH_DEF   = 256;

    // Characters handled by the editor.
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_BS    = 8'h08;
    localparam logic [7:0] CHAR_DEL   = 8'h7F;
    localparam logic [7:0] CHAR_CARET = 8'h5E;

    // Input transaction kinds.
    localparam logic [1:0] KIND_RX      = 2'd0;
    localparam logic [1:0] KIND_TX_DONE = 2'd1;
    localparam logic [1:0] KIND_HOST    = 2'd2;

    // Result kinds.
    localparam logic [1:0] RK_TX   = 2'd0;
    localparam logic [1:0] RK_LINE = 2'd1;
    localparam logic [1:0] RK_END  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_QUEUE,
        ST_QUEUE_CR,
        ST_QUEUE_LF,
        ST_TX_CHECK,
        ST_LINE_READ,
        ST_LINE_CHECK
    } ctrl_state_t;

    // Source of the byte that is queued for transmission or emitted.
    typedef enum logic [2:0] {
        SEL_INPUT,
        SEL_CR,
        SEL_LF,
        SEL_BS,
        SEL_CARET,
        SEL_TX_RD,
        SEL_LINE_RD,
        SEL_ZERO
    } byte_sel_t;

    typedef struct packed {
        logic       in_load;
        logic       line_push;
        logic       line_pop;
        logic       line_start;
        logic       line_next;
        logic       tx_push;
        logic       tx_advance;
        logic       tx_clear;
        logic       emit;
        logic [1:0] emit_kind;
        logic       emit_last;
        byte_sel_t  byte_sel;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] in_kind;
        logic       is_eol;
        logic       is_bs;
        logic       line_empty;
        logic       line_full;
        logic       echo;
        logic       tx_full;
        logic       tx_empty;
        logic       out_free;
        logic       tx_data_ok;
        logic       line_data_ok;
    } dp_status_t;

endpackage

// ===== rtl/core/sle_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// Used for the line store and the transmit store. No dependencies.
module sle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/sle_dpath.sv =====
// Datapath of the serial line editor: input holding registers, line and transmit
// stores with their counters, the echo register and the result output register.
// Depends on sle_pkg and sle_ram.
module sle_dpath #(
    parameter int LINE_DEPTH = sle_pkg::LINE_DEPTH_DEF,
    parameter int TX_DEPTH   = sle_pkg::TX_DEPTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [1:0]             s_kind,
    input  logic [7:0]             s_data_byte,
    input  logic                   cfg_valid,
    input  logic                   cfg_data,
    input  logic                   m_ready,
    output logic                   m_valid,
    output logic [1:0]             m_result_kind,
    output logic [7:0]             m_out_byte,
    output logic                   m_last,
    input  sle_pkg::ctrl_cmd_t     cmd,
    output sle_pkg::dp_status_t    sts
);

    localparam int LW  = $clog2(LINE_DEPTH);
    localparam int TAW = $clog2(TX_DEPTH);
    localparam int TCW = $clog2(TX_DEPTH + 1);

    logic [1:0]   in_kind_reg, in_kind_next;
    logic [7:0]   in_byte_reg, in_byte_next;
    logic [LW-1:0] line_len_reg, line_len_next;
    logic [LW-1:0] emit_len_reg, emit_len_next;
    logic [LW-1:0] idx_reg, idx_next;
    logic [TCW-1:0] tx_count_reg, tx_count_next;
    logic [TCW-1:0] tx_pos_reg, tx_pos_next;
    logic         echo_reg, echo_next;
    logic         out_valid_reg, out_valid_next;
    logic [1:0]   out_kind_reg, out_kind_next;
    logic [7:0]   out_byte_reg, out_byte_next;
    logic         out_last_reg, out_last_next;

    logic [7:0]   line_rdata;
    logic [7:0]   tx_rdata;
    logic [7:0]   sel_byte;
    logic         tx_empty;

    sle_ram #(
        .WIDTH (8),
        .DEPTH (LINE_DEPTH)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (cmd.line_push),
        .wr_addr (line_len_reg),
        .wr_data (in_byte_reg),
        .rd_addr (idx_reg),
        .rd_data (line_rdata)
    );

    sle_ram #(
        .WIDTH (8),
        .DEPTH (TX_DEPTH)
    ) u_tx_ram (
        .aclk    (aclk),
        .wr_en   (cmd.tx_push),
        .wr_addr (tx_count_reg[TAW-1:0]),
        .wr_data (sel_byte),
        .rd_addr (tx_pos_reg[TAW-1:0]),
        .rd_data (tx_rdata)
    );

    always_comb begin
        unique case (cmd.byte_sel)
            sle_pkg::SEL_INPUT:   sel_byte = in_byte_reg;
            sle_pkg::SEL_CR:      sel_byte = sle_pkg::CHAR_CR;
            sle_pkg::SEL_LF:      sel_byte = sle_pkg::CHAR_LF;
            sle_pkg::SEL_BS:      sel_byte = sle_pkg::CHAR_BS;
            sle_pkg::SEL_CARET:   sel_byte = sle_pkg::CHAR_CARET;
            sle_pkg::SEL_TX_RD:   sel_byte = tx_rdata;
            sle_pkg::SEL_LINE_RD: sel_byte = line_rdata;
            sle_pkg::SEL_ZERO:    sel_byte = 8'h00;
            default:              sel_byte = 8'h00;
        endcase
    end

    assign tx_empty = (tx_count_reg == '0);

    always_comb begin
        sts.in_kind      = in_kind_reg;
        sts.is_eol       = (in_byte_reg == sle_pkg::CHAR_CR) || (in_byte_reg == sle_pkg::CHAR_LF);
        sts.is_bs        = (in_byte_reg == sle_pkg::CHAR_BS) || (in_byte_reg == sle_pkg::CHAR_DEL);
        sts.line_empty   = (line_len_reg == '0);
        sts.line_full    = (line_len_reg == LW'(LINE_DEPTH - 1));
        sts.echo         = echo_reg;
        sts.tx_full      = (tx_count_reg == TCW'(TX_DEPTH));
        sts.tx_empty     = tx_empty;
        sts.out_free     = !out_valid_reg || m_ready;
        // A queued zero byte stops transmission just as an exhausted buffer does.
        sts.tx_data_ok   = (tx_pos_reg < tx_count_reg) && (tx_rdata != 8'h00);
        sts.line_data_ok = (idx_reg < emit_len_reg) && (line_rdata != 8'h00);
    end

    always_comb begin
        in_kind_next   = in_kind_reg;
        in_byte_next   = in_byte_reg;
        line_len_next  = line_len_reg;
        emit_len_next  = emit_len_reg;
        idx_next       = idx_reg;
        tx_count_next  = tx_count_reg;
        tx_pos_next    = tx_pos_reg;
        echo_next      = echo_reg;
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;

        if (cmd.in_load) begin
            in_kind_next = s_kind;
            in_byte_next = s_data_byte;
        end

        if (cmd.line_start) begin
            emit_len_next = line_len_reg;
            line_len_next = '0;
            idx_next      = '0;
        end
        if (cmd.line_push) begin
            line_len_next = line_len_reg + LW'(1);
        end
        if (cmd.line_pop) begin
            line_len_next = line_len_reg - LW'(1);
        end
        if (cmd.line_next) begin
            idx_next = idx_reg + LW'(1);
        end

        if (cmd.tx_clear) begin
            tx_count_next = '0;
            tx_pos_next   = '0;
        end
        if (cmd.tx_push) begin
            tx_count_next = tx_count_reg + TCW'(1);
            // The first byte into an idle link goes out at once.
            if (tx_empty) begin
                tx_pos_next = TCW'(1);
            end
        end
        if (cmd.tx_advance) begin
            tx_pos_next = tx_pos_reg + TCW'(1);
        end

        if (cfg_valid) begin
            echo_next = cfg_data;
        end

        if (cmd.emit) begin
            out_valid_next = 1'b1;
            out_kind_next  = cmd.emit_kind;
            out_byte_next  = sel_byte;
            out_last_next  = cmd.emit_last;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_len_reg  <= '0;
            tx_count_reg  <= '0;
            tx_pos_reg    <= '0;
            echo_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            line_len_reg  <= line_len_next;
            tx_count_reg  <= tx_count_next;
            tx_pos_reg    <= tx_pos_next;
            echo_reg      <= echo_next;
            out_valid_reg <= out_valid_next;
        end
        in_kind_reg  <= in_kind_next;
        in_byte_reg  <= in_byte_next;
        emit_len_reg <= emit_len_next;
        idx_reg      <= idx_next;
        out_kind_reg <= out_kind_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_result_kind = out_kind_reg;
    assign m_out_byte    = out_byte_reg;
    assign m_last        = out_last_reg;

endmodule

// ===== rtl/core/sle_ctrl.sv =====
// Controller state machine of the serial line editor.
// Sequences each input transaction into datapath commands; depends on sle_pkg.
module sle_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sle_pkg::dp_status_t sts,
    output sle_pkg::ctrl_cmd_t  cmd
);

    sle_pkg::ctrl_state_t state_reg, state_next;
    sle_pkg::byte_sel_t   sel_reg, sel_next;
    logic                 q_emit;
    logic                 q_go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sle_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        sel_reg <= sel_next;
    end

    // Queueing into an empty transmit store also sends the byte, so it needs the
    // output register; otherwise the step never waits.
    assign q_emit = sts.tx_empty;
    assign q_go   = !q_emit || sts.out_free;

    always_comb begin
        state_next    = state_reg;
        sel_next      = sel_reg;
        cmd           = '0;
        cmd.byte_sel  = sel_reg;
        cmd.emit_kind = sle_pkg::RK_TX;
        s_ready       = 1'b0;

        unique case (state_reg)
            sle_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.in_load = 1'b1;
                    state_next  = sle_pkg::ST_DECODE;
                end
            end

            sle_pkg::ST_DECODE: begin
                priority if (sts.in_kind == sle_pkg::KIND_HOST) begin
                    sel_next   = sle_pkg::SEL_INPUT;
                    state_next = sle_pkg::ST_QUEUE;
                end else if (sts.in_kind == sle_pkg::KIND_TX_DONE) begin
                    state_next = sle_pkg::ST_TX_CHECK;
                end else if (sts.in_kind == sle_pkg::KIND_RX) begin
                    priority if (sts.is_eol) begin
                        cmd.line_start = 1'b1;
                        state_next = sts.echo ? sle_pkg::ST_QUEUE_CR : sle_pkg::ST_LINE_READ;
                    end else if (sts.is_bs) begin
                        state_next = sle_pkg::ST_IDLE;
                        if (!sts.line_empty) begin
                            cmd.line_pop = 1'b1;
                            if (sts.echo) begin
                                sel_next   = sle_pkg::SEL_BS;
                                state_next = sle_pkg::ST_QUEUE;
                            end
                        end
                    end else begin
                        state_next = sle_pkg::ST_IDLE;
                        if (!sts.line_full) begin
                            cmd.line_push = 1'b1;
                            if (sts.echo) begin
                                sel_next   = sle_pkg::SEL_INPUT;
                                state_next = sle_pkg::ST_QUEUE;
                            end
                        end else if (sts.echo) begin
                            sel_next   = sle_pkg::SEL_CARET;
                            state_next = sle_pkg::ST_QUEUE;
                        end
                    end
                end else begin
                    state_next = sle_pkg::ST_IDLE;
                end
            end

            sle_pkg::ST_QUEUE: begin
                cmd.emit_last = 1'b1;
                if (q_go) begin
                    cmd.tx_push = !sts.tx_full;
                    cmd.emit    = q_emit;
                    state_next  = sle_pkg::ST_IDLE;
                end
            end

            sle_pkg::ST_QUEUE_CR: begin
                cmd.byte_sel = sle_pkg::SEL_CR;
                if (q_go) begin
                    cmd.tx_push = !sts.tx_full;
                    cmd.emit    = q_emit;
                    state_next  = sle_pkg::ST_QUEUE_LF;
                end
            end

            sle_pkg::ST_QUEUE_LF: begin
                cmd.byte_sel = sle_pkg::SEL_LF;
                if (q_go) begin
                    cmd.tx_push = !sts.tx_full;
                    cmd.emit    = q_emit;
                    state_next  = sle_pkg::ST_LINE_READ;
                end
            end

            sle_pkg::ST_TX_CHECK: begin
                cmd.byte_sel  = sle_pkg::SEL_TX_RD;
                cmd.emit_last = 1'b1;
                if (sts.tx_data_ok) begin
                    if (sts.out_free) begin
                        cmd.emit       = 1'b1;
                        cmd.tx_advance = 1'b1;
                        state_next     = sle_pkg::ST_IDLE;
                    end
                end else begin
                    cmd.tx_clear = 1'b1;
                    state_next   = sle_pkg::ST_IDLE;
                end
            end

            sle_pkg::ST_LINE_READ: begin
                state_next = sle_pkg::ST_LINE_CHECK;
            end

            sle_pkg::ST_LINE_CHECK: begin
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    if (sts.line_data_ok) begin
                        cmd.byte_sel  = sle_pkg::SEL_LINE_RD;
                        cmd.emit_kind = sle_pkg::RK_LINE;
                        cmd.line_next = 1'b1;
                        state_next    = sle_pkg::ST_LINE_READ;
                    end else begin
                        cmd.byte_sel  = sle_pkg::SEL_ZERO;
                        cmd.emit_kind = sle_pkg::RK_END;
                        cmd.emit_last = 1'b1;
                        state_next    = sle_pkg::ST_IDLE;
                    end
                end
            end

            default: begin
                state_next = sle_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/serial_line_editor_echo_top.sv =====
// Top level of the serial line editor with echo and transmit buffer.
// Joins the controller (sle_ctrl) and the datapath (sle_dpath); depends on sle_pkg.
//
// Usage:
//   Input channel s_*: one transaction per event - a received byte, a transmit-done
//   from the serial link, or a host byte to send. Result channel m_*: bytes to
//   transmit, line bytes and the end-of-line marker; m_last flags the final result
//   of an input transaction. cfg_*: writes the echo enable bit; cfg_ready is always
//   high and writes are meant to happen while the block is idle.
//   Sequencing: a new transaction is accepted only once the controller is back in
//   its idle state. A CR or LF reads the stored line out byte by byte; the line
//   store has a registered read port, so each stored byte passes through a read
//   state (ST_LINE_READ) and then a check state (ST_LINE_CHECK) before it is emitted.
//   The output register lets a new transaction be accepted while the last result
//   still waits; if the receiver stalls, the sequence holds at the next result.
//   Reset (aresetn low, synchronous) empties the line and the transmit buffer,
//   marks the link idle, clears echo enable and drops any pending result.
module serial_line_editor_echo_top #(
    parameter int LINE_DEPTH = sle_pkg::LINE_DEPTH_DEF,
    parameter int TX_DEPTH   = sle_pkg::TX_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_kind,
    input  logic [7:0] s_data_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_result_kind,
    output logic [7:0] m_out_byte,
    output logic       m_last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data
);

    sle_pkg::ctrl_cmd_t  cmd;
    sle_pkg::dp_status_t sts;

    assign cfg_ready = 1'b1;

    sle_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    sle_dpath #(
        .LINE_DEPTH (LINE_DEPTH),
        .TX_DEPTH   (TX_DEPTH)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_kind        (s_kind),
        .s_data_byte   (s_data_byte),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_result_kind (m_result_kind),
        .m_out_byte    (m_out_byte),
        .m_last        (m_last),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule

// ===== rtl/core/sle_checker.sv =====
// Port-level assertions for the serial line editor, bound to its top level.
// Depends on sle_pkg for the result kind codes.
module sle_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_result_kind,
    input logic [7:0] m_out_byte,
    input logic       m_last
);

    // A stalled result keeps its content.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_kind)
            && $stable(m_out_byte) && $stable(m_last))
        else $error("result changed while stalled");

    // Reset drops any pending result.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // The end marker carries a zero byte and closes its transaction.
    a_end_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_result_kind == sle_pkg::RK_END) |-> m_last && (m_out_byte == 8'h00))
        else $error("malformed end-of-line marker");

    // Line bytes are never zero and never close their transaction; the end marker does.
    a_line_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_result_kind == sle_pkg::RK_LINE) |-> !m_last && (m_out_byte != 8'h00))
        else $error("malformed line byte");

    // Only the three defined result kinds appear.
    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_result_kind == sle_pkg::RK_TX) || (m_result_kind == sle_pkg::RK_LINE)
            || (m_result_kind == sle_pkg::RK_END))
        else $error("undefined result kind");

endmodule

bind serial_line_editor_echo_top sle_checker u_sle_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_result_kind (m_result_kind),
    .m_out_byte    (m_out_byte),
    .m_last        (m_last)
);

// ===== verif/serial_line_editor_echo_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for serial_line_editor_echo_top: line editing, echo and transmit buffer.
// Drives random and directed link events, predicts the editor's outputs; depends on sle_pkg.
module serial_line_editor_echo_top_test;
    import sle_pkg::*;

    localparam int LINE_DEPTH    = LINE_DEPTH_DEF;
    localparam int TX_DEPTH      = TX_DEPTH_DEF;
    localparam int CYCLE_LIMIT   = 500_000;
    localparam int DRAIN_LIMIT   = 20_000;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES   = 300;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
    } link_event_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
    } editor_out_t;

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    logic [1:0] s_kind      = KIND_RX;
    logic [7:0] s_data_byte = 8'h00;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    logic [1:0] m_result_kind;
    logic [7:0] m_out_byte;
    logic       m_last;
    logic       cfg_valid   = 1'b0;
    logic       cfg_ready;
    logic       cfg_data    = 1'b0;

    // Stimulus and expectations.
    link_event_t link_event_q[$];
    editor_out_t editor_out_q[$];
    int          send_gap_pct = 0;
    int          recv_gap_pct = 0;
    bit          offer_taken  = 1'b0;
    bit          hold_trigger = 1'b0;
    bit          hold_active  = 1'b0;
    int          mismatch_count = 0;
    int          cycle_count    = 0;

    // Predicted editor state.
    logic [7:0] line_mem [LINE_DEPTH];
    int         line_len  = 0;
    logic [7:0] tx_mem [TX_DEPTH];
    int         tx_cnt    = 0;
    int         tx_pos    = 0;
    bit         link_idle = 1'b1;
    bit         echo_on   = 1'b0;

    serial_line_editor_echo_top uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_kind (m_result_kind),
        .m_out_byte    (m_out_byte),
        .m_last        (m_last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    task automatic report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= 40) begin
            $display("[%0t] %s", $time, msg);
        end
    endtask

    function automatic void add_output(logic [1:0] kind, logic [7:0] data);
        editor_out_t r;
        r.kind = kind;
        r.data = data;
        r.last = 1'b0;
        editor_out_q.push_back(r);
    endfunction

    function automatic void tx_enqueue(logic [7:0] b);
        if (tx_cnt >= TX_DEPTH) begin
            return;
        end
        tx_mem[tx_cnt] = b;
        tx_cnt++;
        // Only the very first byte of an empty buffer goes straight onto an idle link.
        if (tx_cnt == 1 && link_idle) begin
            tx_pos    = 1;
            link_idle = 1'b0;
            add_output(RK_TX, tx_mem[0]);
        end
    endfunction

    function automatic void tx_complete();
        if (tx_pos < tx_cnt && tx_pos < TX_DEPTH && tx_mem[tx_pos] != 8'h00) begin
            add_output(RK_TX, tx_mem[tx_pos]);
            tx_pos++;
        end else begin
            tx_cnt    = 0;
            tx_pos    = 0;
            link_idle = 1'b1;
        end
    endfunction

    function automatic void line_edit(logic [7:0] c);
        int stop;
        if (c == CHAR_LF || c == CHAR_CR) begin
            stop     = line_len;
            line_len = 0;
            if (echo_on) begin
                tx_enqueue(CHAR_CR);
                tx_enqueue(CHAR_LF);
            end
            for (int i = 0; i < stop; i++) begin
                if (line_mem[i] == 8'h00) begin
                    break;
                end
                add_output(RK_LINE, line_mem[i]);
            end
            add_output(RK_END, 8'h00);
        end else if (c == CHAR_BS || c == CHAR_DEL) begin
            if (line_len > 0) begin
                line_len--;
                if (echo_on) begin
                    tx_enqueue(CHAR_BS);
                end
            end
        end else if (line_len < LINE_DEPTH - 1) begin
            line_mem[line_len] = c;
            line_len++;
            if (echo_on) begin
                tx_enqueue(c);
            end
        end else if (echo_on) begin
            tx_enqueue(CHAR_CARET);
        end
    endfunction

    function automatic void editor_predict(logic [1:0] kind, logic [7:0] data);
        int before_cnt;
        before_cnt = editor_out_q.size();
        case (kind)
            KIND_RX:      line_edit(data);
            KIND_TX_DONE: tx_complete();
            KIND_HOST:    tx_enqueue(data);
            default: ;
        endcase
        if (editor_out_q.size() > before_cnt) begin
            editor_out_q[editor_out_q.size() - 1].last = 1'b1;
        end
    endfunction

    // Input transactions are offered from the falling edge.
    always @(negedge aclk) begin : sender
        link_event_t ev;
        if (s_valid && !offer_taken) begin
            // Hold the offer until it is taken.
        end else if (link_event_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
            ev = link_event_q.pop_front();
            s_kind      <= ev.kind;
            s_data_byte <= ev.data;
            s_valid     <= 1'b1;
        end else begin
            s_valid <= 1'b0;
        end
        offer_taken = 1'b0;
    end

    always @(negedge aclk) begin : receiver
        m_ready <= !hold_active && ($urandom_range(0, 99) >= recv_gap_pct);
    end

    initial begin : receiver_hold_off
        wait (hold_trigger);
        @(negedge aclk);
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(negedge aclk);
        hold_active = 1'b0;
    end

    always @(posedge aclk) begin : observer
        editor_out_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                echo_on = cfg_data;
            end
            if (s_valid && s_ready) begin
                editor_predict(s_kind, s_data_byte);
                offer_taken = 1'b1;
            end
            if (m_valid && m_ready) begin
                if (editor_out_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result: kind %0d byte %02h last %0d",
                                              m_result_kind, m_out_byte, m_last));
                end else begin
                    want = editor_out_q.pop_front();
                    if (m_result_kind !== want.kind) begin
                        report_mismatch($sformatf("result_kind %0d, expected %0d",
                                                  m_result_kind, want.kind));
                    end
                    if (m_out_byte !== want.data) begin
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  m_out_byte, want.data));
                    end
                    if (m_last !== want.last) begin
                        report_mismatch($sformatf("last %0d, expected %0d", m_last, want.last));
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("serial_line_editor_echo_top: mismatch");
            $finish;
        end
    end

    task automatic queue_event(logic [1:0] kind, logic [7:0] data);
        link_event_t ev;
        ev.kind = kind;
        ev.data = data;
        link_event_q.push_back(ev);
    endtask

    // A printable or binary byte that the editor stores rather than acts on; never zero.
    function automatic logic [7:0] plain_char();
        logic [7:0] b;
        b = 8'($urandom_range(1, 255));
        if (b == CHAR_LF || b == CHAR_CR || b == CHAR_BS || b == CHAR_DEL) begin
            b = b ^ 8'h40;
        end
        return b;
    endfunction

    task automatic write_echo(logic value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every offered transaction is taken and every result has come back.
    task automatic settle();
        int waited;
        waited = 0;
        while ((link_event_q.size() != 0 || s_valid || editor_out_q.size() != 0)
               && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (editor_out_q.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      editor_out_q.size()));
            editor_out_q.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Mostly complete edited lines, with transmit-done bursts, host bytes and some noise.
    task automatic queue_random(int count);
        int made;
        int pick;
        int len;
        made = 0;
        while (made < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 8);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 7) == 0) begin
                        queue_event(KIND_RX, $urandom_range(0, 1) ? CHAR_BS : CHAR_DEL);
                    end else if ($urandom_range(0, 15) == 0) begin
                        queue_event(KIND_RX, 8'h00);
                    end else begin
                        queue_event(KIND_RX, plain_char());
                    end
                end
                queue_event(KIND_RX, $urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
                made += len + 1;
            end else if (pick < 78) begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++) begin
                    queue_event(KIND_TX_DONE, 8'($urandom_range(0, 255)));
                end
                made += len;
            end else if (pick < 92) begin
                queue_event(KIND_HOST, 8'($urandom_range(0, 255)));
                made++;
            end else if (pick < 96) begin
                // The unused kind is ignored and does not count as stimulus.
                queue_event(2'd3, 8'($urandom_range(0, 255)));
            end else begin
                queue_event(KIND_RX, 8'($urandom_range(0, 255)));
                made++;
            end
        end
    endtask

    initial begin : run
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_gap_pct = 28;
        recv_gap_pct = 77;
        write_echo(1'b1);

        // Directed: idle link, unused kind, backspace on an empty line, zero in a line.
        queue_event(KIND_HOST, 8'h41);
        queue_event(2'd3, 8'hFF);
        queue_event(KIND_TX_DONE, 8'hFF);
        queue_event(KIND_TX_DONE, 8'h00);
        queue_event(KIND_RX, CHAR_BS);
        queue_event(KIND_RX, CHAR_DEL);
        queue_event(KIND_RX, 8'h68);
        queue_event(KIND_RX, 8'h00);
        queue_event(KIND_RX, 8'h69);
        queue_event(KIND_RX, CHAR_DEL);
        queue_event(KIND_RX, CHAR_CR);
        queue_event(KIND_TX_DONE, 8'h00);
        queue_event(KIND_RX, 8'hFF);
        queue_event(KIND_RX, 8'h80);
        queue_event(KIND_RX, CHAR_LF);
        queue_event(KIND_HOST, 8'h00);
        repeat (4) queue_event(KIND_TX_DONE, 8'h55);
        queue_event(2'd3, 8'h00);
        queue_event(KIND_HOST, 8'h00);
        queue_event(KIND_TX_DONE, 8'hAA);

        // Overfill the line so that the caret is echoed.
        for (int i = 0; i < LINE_DEPTH + 1; i++) begin
            queue_event(KIND_RX, plain_char());
        end
        queue_event(KIND_RX, CHAR_CR);
        queue_random(17);
        settle();

        send_gap_pct = 77;
        recv_gap_pct = 28;
        write_echo(1'b0);
        queue_random(17);
        settle();

        send_gap_pct = 0;
        recv_gap_pct = 0;
        write_echo(1'b1);
        // A short line first, so the receiver's hold-off backs results up into the input.
        for (int i = 0; i < 4; i++) begin
            queue_event(KIND_RX, plain_char());
        end
        queue_event(KIND_RX, CHAR_CR);
        queue_random(16);
        hold_trigger = 1'b1;
        settle();

        if (mismatch_count == 0) begin
            $display("serial_line_editor_echo_top: match");
        end else begin
            $display("serial_line_editor_echo_top: mismatch");
        end
        $finish;
    end

endmodule
